FILE: rtl/core/llsig_pkg.sv
// ---------------------------------------------------------------------------
// llsig_pkg: shared types and constants for the lat-long sphere index generator
// Register indexes, field widths, phase codes and the result record.
// ---------------------------------------------------------------------------
package llsig_pkg;

  localparam int CORNER_W      = 16;   // width of each corner index port
  localparam int RING_VERT_W   = 11;   // ring_vertices register width
  localparam int RING_CNT_W    = 6;    // ring_count register width
  localparam int COLUMN_W      = 10;   // column counter width
  localparam int CFG_DATA_W    = 11;   // widest configuration register
  localparam int CFG_INDEX_W   = 1;    // two registers
  localparam int INDEX_WIDTH_DEFAULT = 16;

  localparam logic [RING_VERT_W-1:0] RING_VERT_MIN   = 11'd3;
  localparam logic [RING_VERT_W-1:0] RING_VERT_MAX   = 11'd1024;
  localparam logic [RING_VERT_W-1:0] RING_VERT_RESET = 11'd4;
  localparam logic [RING_CNT_W-1:0]  RING_CNT_RESET  = 6'd1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_RING_VERTICES = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RING_COUNT    = 1'b1;

  // generator phase, one-hot
  typedef enum logic [2:0] {
    PH_TOP    = 3'b001,
    PH_BANDS  = 3'b010,
    PH_BOTTOM = 3'b100
  } phase_t;

  // one triangle as it leaves the block
  typedef struct packed {
    logic [CORNER_W-1:0] corner_first;
    logic [CORNER_W-1:0] corner_second;
    logic [CORNER_W-1:0] corner_third;
    logic                last_triangle;
  } tri_t;

endpackage

FILE: rtl/core/latlong_sphere_index_generator_core.sv
// ---------------------------------------------------------------------------
// latlong_sphere_index_generator_core: triangle index list of a UV sphere mesh
// Walks top fan, quad bands and bottom fan, one triangle per transfer.
// ---------------------------------------------------------------------------
// Every accepted input transfer yields exactly one triangle on the output
// channel. The block takes one input transfer per clock while the skid entry
// is empty: the walk counters (phase, column, band, quad half, ring base) are
// updated by a single pass of adds and compares at the accepting edge, which
// registers the triangle in the output entry, or in the skid entry if that is
// full. Throughput is one triangle per cycle while out_ready holds; the skid
// entry keeps a transfer going on a stall; in_ready is a plain register output.
// Vertex 0 is the top pole, ring r starts at 1 + r*ring_vertices, and the
// bottom pole is ring_count*ring_vertices + 1. Indices are wrapped to
// INDEX_WIDTH bits (and to the 16-bit ports). Setting in_restart on a transfer
// starts over at the first top-fan triangle, which is emitted on that
// transfer. ring_vertices is clamped to 3..1024 and ring_count 0 acts as 1.
// Write the configuration registers only while the block is idle.
// ---------------------------------------------------------------------------
module latlong_sphere_index_generator_core
  import llsig_pkg::*;
#(
  parameter int INDEX_WIDTH = INDEX_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  // input channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_restart,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [CORNER_W-1:0]    out_corner_first,
  output logic [CORNER_W-1:0]    out_corner_second,
  output logic [CORNER_W-1:0]    out_corner_third,
  output logic                   out_last_triangle
);

  // indices are cut to INDEX_WIDTH, then to the port width
  localparam int OUT_BITS = (INDEX_WIDTH < CORNER_W) ? INDEX_WIDTH : CORNER_W;
  localparam logic [CORNER_W-1:0] IDX_MASK =
    CORNER_W'((17'(1) << OUT_BITS) - 17'd1);

  // configuration
  logic [RING_VERT_W-1:0] ring_vertices_r;
  logic [RING_CNT_W-1:0]  ring_count_r;

  // walk state
  phase_t                 phase_r, phase_nxt;
  logic [COLUMN_W-1:0]    column_r, column_nxt;
  logic [RING_CNT_W-1:0]  band_r, band_nxt;
  logic                   half_r, half_nxt;
  logic [CORNER_W-1:0]    ring_base_r, ring_base_nxt;

  // output entry plus skid entry
  tri_t                   out_r, skid_r, tri_nxt;
  logic                   out_valid_r, skid_valid_r;

  logic push, pop;

  // effective (clamped) configuration
  logic [RING_VERT_W-1:0] n_eff;
  logic [RING_CNT_W-1:0]  r_eff;

  // state after an optional restart
  phase_t                 ph_cur;
  logic [COLUMN_W-1:0]    col_cur;
  logic [RING_CNT_W-1:0]  band_cur;
  logic                   half_cur;
  logic [CORNER_W-1:0]    base_cur;

  logic                   at_end;
  logic [CORNER_W-1:0]    n16, cur, nxt, pole;
  logic [16:0]            pole_full;
  logic [CORNER_W-1:0]    a, b, c;
  logic                   last;

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_vertices_r <= RING_VERT_RESET;
      ring_count_r    <= RING_CNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RING_VERTICES: ring_vertices_r <= cfg_wdata;
        CFG_RING_COUNT:    ring_count_r    <= cfg_wdata[RING_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (ring_vertices_r < RING_VERT_MIN)      n_eff = RING_VERT_MIN;
    else if (ring_vertices_r > RING_VERT_MAX) n_eff = RING_VERT_MAX;
    else                                      n_eff = ring_vertices_r;
    r_eff = (ring_count_r == '0) ? RING_CNT_W'(1) : ring_count_r;
  end

  // ------------------------------------------------------------------
  // Handshake
  // ------------------------------------------------------------------
  assign in_ready = !skid_valid_r;
  assign push     = in_valid && in_ready;
  assign pop      = out_valid_r && out_ready;

  // ------------------------------------------------------------------
  // Triangle and next-state logic
  // ------------------------------------------------------------------
  always_comb begin
    ph_cur   = in_restart ? PH_TOP : phase_r;
    col_cur  = in_restart ? '0 : column_r;
    band_cur = in_restart ? '0 : band_r;
    half_cur = in_restart ? 1'b0 : half_r;
    base_cur = in_restart ? CORNER_W'(1) : ring_base_r;

    at_end    = {1'b0, col_cur} >= (n_eff - RING_VERT_W'(1));
    n16       = CORNER_W'(n_eff);
    cur       = base_cur + CORNER_W'(col_cur);
    nxt       = at_end ? base_cur : cur + CORNER_W'(1);
    pole_full = 17'(r_eff) * 17'(n_eff) + 17'd1;
    pole      = pole_full[CORNER_W-1:0];

    phase_nxt     = ph_cur;
    column_nxt    = col_cur + COLUMN_W'(1);
    band_nxt      = band_cur;
    half_nxt      = half_cur;
    ring_base_nxt = base_cur;
    last          = 1'b0;

    unique case (ph_cur)
      PH_BANDS: begin
        if (!half_cur) begin
          a = nxt;
          b = cur + n16;
          c = cur;
          half_nxt   = 1'b1;
          column_nxt = col_cur;
        end else begin
          a = nxt + n16;
          b = cur + n16;
          c = nxt;
          half_nxt = 1'b0;
          if (at_end) begin
            column_nxt    = '0;
            band_nxt      = band_cur + RING_CNT_W'(1);
            ring_base_nxt = base_cur + n16;
            // bands are done once the advanced band count reaches r - 1
            if (band_nxt >= r_eff - RING_CNT_W'(1)) phase_nxt = PH_BOTTOM;
          end
        end
      end
      PH_BOTTOM: begin
        a = nxt;
        b = pole;
        c = cur;
        if (at_end) begin
          last          = 1'b1;
          phase_nxt     = PH_TOP;
          column_nxt    = '0;
          band_nxt      = '0;
          half_nxt      = 1'b0;
          ring_base_nxt = CORNER_W'(1);
        end
      end
      default: begin
        // top fan
        a = nxt;
        b = cur;
        c = '0;
        if (at_end) begin
          column_nxt    = '0;
          band_nxt      = '0;
          half_nxt      = 1'b0;
          ring_base_nxt = CORNER_W'(1);
          phase_nxt     = (r_eff >= RING_CNT_W'(2)) ? PH_BANDS : PH_BOTTOM;
        end
      end
    endcase

    tri_nxt.corner_first  = a & IDX_MASK;
    tri_nxt.corner_second = b & IDX_MASK;
    tri_nxt.corner_third  = c & IDX_MASK;
    tri_nxt.last_triangle = last;
  end

  // walk state advances on every input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TOP;
      column_r    <= '0;
      band_r      <= '0;
      half_r      <= 1'b0;
      ring_base_r <= CORNER_W'(1);
    end else if (push) begin
      phase_r     <= phase_nxt;
      column_r    <= column_nxt;
      band_r      <= band_nxt;
      half_r      <= half_nxt;
      ring_base_r <= ring_base_nxt;
    end
  end

  // ------------------------------------------------------------------
  // Output register with skid entry
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push && out_valid_r && !pop) begin
      skid_valid_r <= 1'b1;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) out_r <= skid_r;
    end else if (push && out_valid_r && !pop) begin
      skid_r <= tri_nxt;
    end else if (push) begin
      out_r <= tri_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_corner_first  = out_r.corner_first;
  assign out_corner_second = out_r.corner_second;
  assign out_corner_third  = out_r.corner_third;
  assign out_last_triangle = out_r.last_triangle;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  // the skid entry is only ever filled behind a full output entry
  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid while output entry empty");

  // finishing the bottom fan returns the walk to the start of a top fan
  a_wrap_to_top : assert property (@(posedge clk) disable iff (!rst_n)
    (push && ph_cur == PH_BOTTOM && at_end) |=>
      (phase_r == PH_TOP && column_r == '0 && ring_base_r == CORNER_W'(1)))
    else $error("walk did not wrap after last bottom-fan triangle");

  // a restart transfer always emits a top-fan triangle with the top pole
  a_restart_top_pole : assert property (@(posedge clk) disable iff (!rst_n)
    (push && in_restart) |-> (tri_nxt.corner_third == '0 && !tri_nxt.last_triangle))
    else $error("restart did not produce a top-fan triangle");

  // the first half of a quad never moves the column
  a_quad_first_half : assert property (@(posedge clk) disable iff (!rst_n)
    (push && ph_cur == PH_BANDS && !half_cur) |=>
      (half_r && column_r == $past(col_cur)))
    else $error("first quad triangle advanced the column");

endmodule
